// ===== hdl/mblt_pkg.sv =====
package mblt_pkg;

    localparam int MAC_W    = 48;
    localparam int CMD_W    = 2;
    localparam int OUT_CNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_APPLY,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/mblt_ram.sv =====
module mblt_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/mac_block_list_table_core.sv =====
// each entry scanned takes a read state and a compare state, then the apply and output
//   states follow; a remove adds a shift state per entry moved down behind the hit
// the serial table scan runs through a shared 48-bit comparator, and out_stall holds the
//   output state; one item at a time, in_stall high while busy
// reset: asynchronous active-low, clears the entry count and sequencer; table contents
//   are left as they are and never read above the count
module mac_block_list_table_core
    import mblt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [MAC_W-1:0]     mac_addr,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 is_listed,
    output logic                 status,
    output logic [OUT_CNT_W-1:0] entry_count
);

    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_EXT_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [MAC_W-1:0]   mac_reg, mac_next;
    logic               found_reg, found_next;
    logic               status_reg, status_next;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [MAC_W-1:0]   ram_wdata, ram_rdata;

    logic [CNT_W-1:0]   idx_ext, idx_plus1, idx_plus2;
    logic               hit, full;
    logic [CNT_EXT_W-1:0] count_ext;

    mblt_ram #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (MAC_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_ext   = CNT_W'(idx_reg);
    assign idx_plus1 = idx_ext + CNT_W'(1);
    assign idx_plus2 = idx_ext + CNT_W'(2);
    assign hit       = (ram_rdata == mac_reg);
    assign full      = (count_reg >= CNT_W'(MAX_ENTRIES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cmd_reg    <= cmd_next;
        mac_reg    <= mac_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        mac_next    = mac_reg;
        found_next  = found_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = mac_reg;
        ram_re      = 1'b0;
        ram_raddr   = idx_reg;
        in_stall    = 1'b1;
        out_valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd_next    = cmd;
                    mac_next    = mac_addr;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = 1'b0;
                    state_next  = (count_reg == '0) ? ST_APPLY : ST_READ;
                end
            end

            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    state_next = ST_APPLY;
                end
                else if (idx_plus1 >= count_reg)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    idx_next   = idx_plus1[IDX_W-1:0];
                    state_next = ST_READ;
                end
            end

            ST_APPLY:
            begin
                state_next = ST_DONE;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (!found_reg)
                        begin
                            if (full)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            if (idx_plus1 < count_reg)
                            begin
                                // fetch the entry behind the hit to move it down
                                ram_re     = 1'b1;
                                ram_raddr  = idx_plus1[IDX_W-1:0];
                                state_next = ST_SHIFT;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if (idx_plus2 < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_plus2[IDX_W-1:0];
                    idx_next  = idx_plus1[IDX_W-1:0];
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_ext   = CNT_EXT_W'(count_reg);
    assign is_listed   = found_reg;
    assign status      = status_reg;
    assign entry_count = count_ext[OUT_CNT_W-1:0];

endmodule

// ===== tb/mblt_checker.sv =====
`timescale 1ns / 100ps

module mblt_checker
    import mblt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [MAC_W-1:0]     mac_addr,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 is_listed,
    input  logic                 status,
    input  logic [OUT_CNT_W-1:0] entry_count,
    output int                   fails,
    output int                   pending
);

    typedef struct packed {
        logic                 listed;
        logic                 full;
        logic [OUT_CNT_W-1:0] count;
    } lookup_reply_t;

    logic [MAC_W-1:0] blocked_macs [MAX_ENTRIES];
    int               blocked_cnt;
    lookup_reply_t    reply_q [$];

    // update the shadow list for one item and queue the reply it should produce
    task automatic apply_command(input logic [CMD_W-1:0] c, input logic [MAC_W-1:0] m);
        int            hit;
        lookup_reply_t r;
        hit = -1;
        for (int i = 0; i < blocked_cnt; i++)
        begin
            if (hit < 0 && blocked_macs[i] == m)
                hit = i;
        end
        r.listed = (hit >= 0);
        r.full   = 1'b0;
        case (c)
            CMD_ADD:
            begin
                if (hit < 0)
                begin
                    if (blocked_cnt >= MAX_ENTRIES)
                        r.full = 1'b1;
                    else
                    begin
                        blocked_macs[blocked_cnt] = m;
                        blocked_cnt++;
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (hit >= 0)
                begin
                    // close the gap behind the removed entry
                    for (int i = hit; i + 1 < blocked_cnt; i++)
                        blocked_macs[i] = blocked_macs[i + 1];
                    blocked_cnt--;
                end
            end
            default:
            begin
                // lookup and the spare code change nothing
            end
        endcase
        r.count = blocked_cnt[OUT_CNT_W-1:0];
        reply_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_reply_t want;
        int            errs;
        if (!rst_n)
        begin
            blocked_cnt = 0;
            reply_q.delete();
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            errs = 0;
            if (in_valid && !in_stall)
                apply_command(cmd, mac_addr);
            if (out_valid && !out_stall)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("result with no item waiting for it");
                    errs++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (is_listed !== want.listed)
                    begin
                        $error("is_listed: expected %0d, got %0d", want.listed, is_listed);
                        errs++;
                    end
                    if (status !== want.full)
                    begin
                        $error("status: expected %0d, got %0d", want.full, status);
                        errs++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                        errs++;
                    end
                end
            end
            fails   <= fails + errs;
            pending <= reply_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import mblt_pkg::*;

    localparam int               MAX_ENTRIES = 16;
    localparam int               POOL_SIZE   = 24;
    localparam int               RAND_ITEMS  = 530;
    localparam int               CYCLE_LIMIT = 400000;
    localparam int               DRAIN       = 3 * MAX_ENTRIES + 12;
    localparam int               HOLD_OFF    = 400;
    localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd = CMD_LOOKUP;
    logic [MAC_W-1:0]     mac_addr = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 is_listed;
    logic                 status;
    logic [OUT_CNT_W-1:0] entry_count;
    int                   fails;
    int                   pending;
    int                   cycles = 0;

    logic [MAC_W-1:0]     mac_pool [POOL_SIZE];
    bit                   send_burst = 1'b0;

    mac_block_list_table_core #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .mac_addr    (mac_addr),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_listed   (is_listed),
        .status      (status),
        .entry_count (entry_count)
    );

    mblt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .mac_addr    (mac_addr),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_listed   (is_listed),
        .status      (status),
        .entry_count (entry_count),
        .fails       (fails),
        .pending     (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    // offer one item after a random gap and hold it until accepted
    task automatic send_command(input logic [CMD_W-1:0] c, input logic [MAC_W-1:0] m);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        mac_addr <= m;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // result side: random stall before each item, one long hold-off
    initial
    begin
        int stall_len;
        int taken;
        bit no_stall;
        taken    = 0;
        no_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (taken % 50 == 0)
                no_stall = ($urandom_range(0, 3) == 0);
            if (taken == 150)
                stall_len = HOLD_OFF;
            else if (no_stall)
                stall_len = 0;
            else
                stall_len = $urandom_range(0, 19);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    initial
    begin
        logic [CMD_W-1:0] c;
        logic [MAC_W-1:0] m;
        int               phase;
        int               r;

        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
        begin
            // some neighbors differ in a single bit to stress the compare
            if (k % 3 == 0)
                mac_pool[k] = mac_pool[k - 1] ^ (48'd1 << $urandom_range(0, MAC_W - 1));
            else
                mac_pool[k] = random_mac();
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        send_command(CMD_LOOKUP, mac_pool[0]);
        send_command(CMD_REMOVE, mac_pool[1]);
        send_command(CMD_ADD, mac_pool[0]);
        send_command(CMD_ADD, mac_pool[1]);
        send_command(CMD_ADD, mac_pool[1]);
        send_command(CMD_SPARE, mac_pool[1]);
        for (int k = 2; k < MAX_ENTRIES; k++)
            send_command(CMD_ADD, mac_pool[k]);
        send_command(CMD_ADD, mac_pool[MAX_ENTRIES]);
        send_command(CMD_ADD, mac_pool[5]);
        send_command(CMD_REMOVE, mac_pool[0]);
        send_command(CMD_REMOVE, mac_pool[MAX_ENTRIES - 1]);
        send_command(CMD_REMOVE, mac_pool[8]);

        // random part: phases lean toward filling or draining the list, or mix the commands
        phase = 0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 60 == 0)
                phase = $urandom_range(0, 2);
            if (n % 64 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            case (phase)
                1:       c = (r < 25) ? CMD_LOOKUP : (r < 75) ? CMD_ADD :
                             (r < 92) ? CMD_REMOVE : CMD_SPARE;
                2:       c = (r < 25) ? CMD_LOOKUP : (r < 40) ? CMD_ADD :
                             (r < 95) ? CMD_REMOVE : CMD_SPARE;
                default: c = (r < 40) ? CMD_LOOKUP : (r < 70) ? CMD_ADD :
                             (r < 95) ? CMD_REMOVE : CMD_SPARE;
            endcase
            if ($urandom_range(0, 3) == 0)
                m = random_mac();
            else
                m = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_command(c, m);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
